// ----- rtl/core/mdps_pkg.sv -----
// ----------------------------------------------------------------------------
// mdps_pkg: shared definitions of the minimum-distance point suppressor
// Register indexes, register widths and reset values, and the status
// record that the distance unit hands to the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdps_pkg;

  // Default sizing of the kept-point store and of the coordinates.
  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_COORD_BITS = 12;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST_SQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT   = 2'd1;

  // Register widths and reset values.
  localparam int THR_W   = 25;
  localparam int LIMIT_W = 9;
  localparam logic [THR_W-1:0]   MIN_DIST_SQ_RESET = 25'd100;
  localparam logic [LIMIT_W-1:0] MAX_COUNT_RESET   = 9'd200;

  // Width of the slot field of a result item.
  localparam int SLOT_W = 8;

  // Status of the distance unit, seen by the sequencer every cycle.
  typedef struct packed {
    logic valid;  // a compare result is present this cycle
    logic near;   // that point lies closer than the threshold
    logic busy;   // some compare is still inside the unit
  } dist_stat_t;

endpackage

// ----- rtl/core/mdps_point_mem.sv -----
// ----------------------------------------------------------------------------
// mdps_point_mem: store of the kept points
// One write port and one registered read port. Each entry holds the x and y
// coordinates of one kept point. A valid flag follows the read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdps_point_mem #(
  parameter int DEPTH      = 256,
  parameter int IDX_W      = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  flush,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic                  rd_valid,
  output logic [COORD_BITS-1:0] rd_x,
  output logic [COORD_BITS-1:0] rd_y
);

  logic [2*COORD_BITS-1:0] mem [DEPTH];
  logic [2*COORD_BITS-1:0] rd_word;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // The valid flag is dropped whenever the sequencer leaves the scan.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  assign rd_x = rd_word[2*COORD_BITS-1:COORD_BITS];
  assign rd_y = rd_word[COORD_BITS-1:0];

endmodule

// ----- rtl/core/mdps_dist_unit.sv -----
// ----------------------------------------------------------------------------
// mdps_dist_unit: shared squared-distance compare
// Two-stage pipeline: absolute differences and squares, then the sum and
// the compare against the threshold. One kept point enters per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdps_dist_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        flush,
  input  logic                        in_valid,
  input  logic [COORD_BITS-1:0]       px,
  input  logic [COORD_BITS-1:0]       py,
  input  logic [COORD_BITS-1:0]       kx,
  input  logic [COORD_BITS-1:0]       ky,
  input  logic [mdps_pkg::THR_W-1:0]  thr,
  output mdps_pkg::dist_stat_t        stat
);

  import mdps_pkg::*;

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_y;
  logic                  s1_valid;
  logic [SUM_W-1:0]      sum;
  logic                  s2_valid;
  logic                  s2_near;

  // Absolute coordinate differences.
  always_comb begin
    dx = (px >= kx) ? (px - kx) : (kx - px);
    dy = (py >= ky) ? (py - ky) : (ky - py);
  end

  // Stage one: the two squares.
  always_ff @(posedge clk) begin
    sq_x <= SQ_W'(dx) * SQ_W'(dx);
    sq_y <= SQ_W'(dy) * SQ_W'(dy);
  end

  // Stage two: sum and compare against the threshold.
  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y);

  always_ff @(posedge clk) begin
    s2_near <= CMP_W'(sum) < CMP_W'(thr);
  end

  // Valid flags of both stages, dropped on a flush.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  assign stat.valid = s2_valid;
  assign stat.near  = s2_near;
  assign stat.busy  = s1_valid | s2_valid;

endmodule

// ----- rtl/core/min_distance_point_suppressor.sv -----
// ----------------------------------------------------------------------------
// min_distance_point_suppressor: greedy minimum-distance point suppression
// Candidate points enter strongest first on the input channel (in_valid,
// in_ready). A point is kept when no point kept earlier in its set lies at a
// squared distance below min_dist_sq, and while fewer points are held than
// the count limit. set_start empties the kept list before its point is tested.
// Each item gives one result item (accepted, slot, list_full) on the output
// channel. Registers are written through the cfg channel (cfg_index 0:
// min_dist_sq, 1: count limit; other indexes are ignored). The user must
// write them only while idle; the block itself does not enforce it. When a
// scan runs to the end, the sequencer reads one kept point per cycle from
// the single read port of the point store into the distance unit; the scan
// stops early on the first close point. Points checked without a scan (list
// full, empty list, zero threshold) go from idle straight to the finish state.
// The next item is taken while a result waits in the output register; if the
// receiver stalls, a finished item waits until the output register is free.
// Reset clears the kept count and loads the register defaults; the store
// itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_distance_point_suppressor #(
  parameter int MAX_POINTS = mdps_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS = mdps_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COORD_BITS-1:0]          point_x,
  input  logic [COORD_BITS-1:0]          point_y,
  input  logic                           set_start,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           accepted,
  output logic [mdps_pkg::SLOT_W-1:0]    slot,
  output logic                           list_full,
  // Configuration channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mdps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdps_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mdps_pkg::*;

  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int IDX_RAW = $clog2(MAX_POINTS);
  localparam int IDX_W   = (IDX_RAW < 1) ? 1 : IDX_RAW;
  localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                state;
  logic [THR_W-1:0]      min_dist_sq;
  logic [LIMIT_W-1:0]    count_limit;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      issue_idx;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic                  room;
  logic                  hit;

  logic [LIM_W-1:0]      lim;
  logic [CNT_W-1:0]      cnt_start;
  logic                  room_start;
  logic                  issue;
  logic                  flush;
  logic                  close_now;
  logic                  scan_done;
  logic                  keep;
  logic                  fire;
  logic [CNT_W-1:0]      count_next;

  logic                  rd_valid;
  logic [COORD_BITS-1:0] rd_x;
  logic [COORD_BITS-1:0] rd_y;
  dist_stat_t            dstat;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist_sq <= MIN_DIST_SQ_RESET;
      count_limit <= MAX_COUNT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MIN_DIST_SQ) begin
        min_dist_sq <= cfg_data[THR_W-1:0];
      end else if (cfg_index == REG_MAX_COUNT) begin
        count_limit <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // Effective limit: the count limit capped at the store depth.
  always_comb begin
    if (LIM_W'(count_limit) > LIM_W'(MAX_POINTS)) begin
      lim = LIM_W'(MAX_POINTS);
    end else begin
      lim = LIM_W'(count_limit);
    end
  end

  // Count seen by a new item, after an optional set start.
  assign cnt_start  = set_start ? '0 : count;
  assign room_start = LIM_W'(cnt_start) < lim;

  // Scan control: one read per cycle until every kept point is issued or a close point is found.
  assign issue     = (state == ST_SCAN) && (issue_idx < count);
  assign flush     = (state != ST_SCAN);
  assign close_now = dstat.valid && dstat.near;
  assign scan_done = close_now ||
                     ((issue_idx == count) && !rd_valid && !dstat.busy);

  // Decision and hand-off to the output register.
  assign keep       = room && !hit;
  assign fire       = (state == ST_FINISH) && (!out_valid || out_ready);
  assign count_next = keep ? (count + CNT_W'(1)) : count;

  assign in_ready = (state == ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      issue_idx <= '0;
      room      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            count     <= cnt_start;
            room      <= room_start;
            hit       <= 1'b0;
            issue_idx <= '0;
            if (room_start && (min_dist_sq != '0) && (cnt_start != '0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          if (close_now) begin
            hit <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fire) begin
            count <= count_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Candidate point, held for the whole item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_x <= point_x;
      cur_y <= point_y;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted  <= keep;
      slot      <= keep ? SLOT_W'(count) : '0;
      list_full <= LIM_W'(count_next) >= lim;
    end
  end

  // Kept-point store.
  mdps_point_mem #(
    .DEPTH      (MAX_POINTS),
    .IDX_W      (IDX_W),
    .COORD_BITS (COORD_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .flush    (flush),
    .wr_en    (fire && keep),
    .wr_addr  (count[IDX_W-1:0]),
    .wr_x     (cur_x),
    .wr_y     (cur_y),
    .rd_en    (issue),
    .rd_addr  (issue_idx[IDX_W-1:0]),
    .rd_valid (rd_valid),
    .rd_x     (rd_x),
    .rd_y     (rd_y)
  );

  // Shared distance compare.
  mdps_dist_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .flush    (flush),
    .in_valid (rd_valid),
    .px       (cur_x),
    .py       (cur_y),
    .kx       (rd_x),
    .ky       (rd_y),
    .thr      (min_dist_sq),
    .stat     (dstat)
  );

endmodule
